// ----- rtl/hlns_pkg.sv -----
`default_nettype none
package hlns_pkg;

  localparam int TABLES_DEF     = 8;
  localparam int PLANES_DEF     = 4;
  localparam int DIM_DEF        = 16;
  localparam int MAX_POINTS_DEF = 32;

  localparam int ACT_W   = 2;
  localparam int TIDX_W  = 3;
  localparam int PIDX_W  = 2;
  localparam int DIDX_W  = 4;
  localparam int COEF_W  = 11;
  localparam int PT_W    = 16;
  localparam int DIST_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic take_in;     // latch request
    logic load_wr;     // write coefficient
    logic sum_clr;     // clear plane accumulators
    logic sum_acc;     // accumulate one dim (coef read in prior cycle)
    logic key_done;    // fold accumulators into key
    logic key_wr;      // insert: write key for current table
    logic pt_wr;       // insert: write point, bump count
    logic cnt_clr;     // clear points
    logic cmp;         // query: compare one stored point
    logic res_load;    // load result register
  } hlns_cmd_t;

  typedef struct packed {
    logic full;
  } hlns_sts_t;

endpackage
`default_nettype wire

// ----- rtl/hlns_if.sv -----
`default_nettype none
interface hlns_in_if;
  logic                           valid;
  logic                           ready;
  logic [hlns_pkg::ACT_W-1:0]     action;
  logic [hlns_pkg::TIDX_W-1:0]    table_index;
  logic [hlns_pkg::PIDX_W-1:0]    plane_index;
  logic [hlns_pkg::DIDX_W-1:0]    dim_index;
  logic signed [hlns_pkg::COEF_W-1:0] coefficient;
  logic [hlns_pkg::PT_W-1:0]      point_bits;
  modport source (output valid, action, table_index, plane_index, dim_index,
                  coefficient, point_bits, input ready);
  modport sink (input valid, action, table_index, plane_index, dim_index,
                coefficient, point_bits, output ready);
endinterface

interface hlns_out_if;
  logic                        valid;
  logic                        ready;
  logic [hlns_pkg::ACT_W-1:0]  kind;
  logic                        found;
  logic [hlns_pkg::PT_W-1:0]   neighbour_bits;
  logic [hlns_pkg::DIST_W-1:0] distance;
  logic                        store_full;
  modport source (output valid, kind, found, neighbour_bits, distance, store_full,
                  input ready);
  modport sink (input valid, kind, found, neighbour_bits, distance, store_full,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/hlns_datapath.sv -----
`default_nettype none
module hlns_datapath #(
  parameter int TABLES     = hlns_pkg::TABLES_DEF,
  parameter int PLANES     = hlns_pkg::PLANES_DEF,
  parameter int DIM        = hlns_pkg::DIM_DEF,
  parameter int MAX_POINTS = hlns_pkg::MAX_POINTS_DEF,
  localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1,
  localparam int PW = (PLANES > 1) ? $clog2(PLANES) : 1,
  localparam int DW = (DIM > 1) ? $clog2(DIM) : 1,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire hlns_pkg::hlns_cmd_t              cmd,
  output hlns_pkg::hlns_sts_t                   sts,
  // sequencing indices from the controller
  input  wire [TW-1:0]                          t_idx,
  input  wire [DW-1:0]                          d_idx,
  input  wire [AW-1:0]                          p_idx,
  input  wire [hlns_pkg::DIST_W-1:0]            dims_eff,
  input  wire [PW:0]                            planes_eff,
  input  wire [hlns_pkg::DIST_W-1:0]            dist_limit,
  output logic [CW-1:0]                         count,
  // request
  input  wire [hlns_pkg::ACT_W-1:0]             in_action,
  input  wire [hlns_pkg::TIDX_W-1:0]            in_table_index,
  input  wire [hlns_pkg::PIDX_W-1:0]            in_plane_index,
  input  wire [hlns_pkg::DIDX_W-1:0]            in_dim_index,
  input  wire signed [hlns_pkg::COEF_W-1:0]     in_coefficient,
  input  wire [hlns_pkg::PT_W-1:0]              in_point_bits,
  // result
  output logic [hlns_pkg::ACT_W-1:0]            res_kind,
  output logic                                  res_found,
  output logic [hlns_pkg::PT_W-1:0]             res_nb,
  output logic [hlns_pkg::DIST_W-1:0]           res_dist,
  output logic                                  res_full
);
  localparam int SUM_W = hlns_pkg::COEF_W + DW + 1;
  localparam int CD    = TABLES * DIM;   // one row per table and dim, all planes wide
  localparam int CAW   = $clog2(CD) > 0 ? $clog2(CD) : 1;

  // latched request
  logic [hlns_pkg::ACT_W-1:0]  act_r;
  logic [hlns_pkg::TIDX_W-1:0] ti_r;
  logic [hlns_pkg::PIDX_W-1:0] pi_r;
  logic [hlns_pkg::DIDX_W-1:0] di_r;
  logic signed [hlns_pkg::COEF_W-1:0] coef_r;
  logic [hlns_pkg::PT_W-1:0]   pt_r;
  logic                        full_r;

  // store state as the request arrives
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      act_r  <= in_action;
      ti_r   <= in_table_index;
      pi_r   <= in_plane_index;
      di_r   <= in_dim_index;
      coef_r <= in_coefficient;
      pt_r   <= in_point_bits;
      full_r <= sts.full;
    end
  end

  // coefficient memory, one entry per plane in a row: per-plane write enables
  logic signed [hlns_pkg::COEF_W-1:0] coef_mem [PLANES][CD];
  logic signed [hlns_pkg::COEF_W-1:0] coef_rd_r [PLANES];
  logic [CAW-1:0] wr_addr, rd_addr;
  logic           load_ok;

  always_comb begin
    load_ok = (32'(ti_r) < TABLES) && (32'(pi_r) < PLANES) && (32'(di_r) < DIM);
    wr_addr = CAW'(32'(ti_r) * DIM + 32'(di_r));
    rd_addr = CAW'(32'(t_idx) * DIM + 32'(d_idx));
  end

  for (genvar j = 0; j < PLANES; j++) begin : g_plane
    always_ff @(posedge clk) begin
      if (cmd.load_wr && load_ok && (32'(pi_r) == j))
        coef_mem[j][wr_addr] <= coef_r;
      coef_rd_r[j] <= coef_mem[j][rd_addr];
    end
  end

  // plane accumulators; dim index of the data now read is one behind
  logic signed [SUM_W-1:0] sum_r [PLANES];
  logic [DW-1:0] d_prev_r;
  always_ff @(posedge clk) d_prev_r <= d_idx;

  for (genvar j = 0; j < PLANES; j++) begin : g_acc
    always_ff @(posedge clk) begin
      if (cmd.sum_clr)
        sum_r[j] <= '0;
      else if (cmd.sum_acc && pt_r[d_prev_r])
        sum_r[j] <= sum_r[j] + SUM_W'(coef_rd_r[j]);
    end
  end

  // key from sums
  logic [PLANES-1:0] key_r, key_c;
  always_comb begin
    for (int j = 0; j < PLANES; j++)
      key_c[j] = (sum_r[j] > 0) && (j < 32'(planes_eff));
  end
  always_ff @(posedge clk) if (cmd.key_done) key_r <= key_c;

  // point and key stores
  logic [hlns_pkg::PT_W-1:0] pt_mem [MAX_POINTS];
  logic [PLANES-1:0]         key_mem [TABLES * MAX_POINTS];
  logic [CW-1:0]             count_r;
  logic [hlns_pkg::PT_W-1:0] pt_rd_r;
  logic [PLANES-1:0]         key_rd_r;
  localparam int KAW = $clog2(TABLES * MAX_POINTS) > 0 ? $clog2(TABLES * MAX_POINTS) : 1;
  logic [KAW-1:0] key_addr;
  assign key_addr = KAW'(32'(t_idx) * MAX_POINTS + 32'(p_idx));

  always_ff @(posedge clk) begin
    if (cmd.pt_wr) pt_mem[count_r[AW-1:0]] <= pt_r;
    pt_rd_r <= pt_mem[p_idx];
  end
  always_ff @(posedge clk) begin
    if (cmd.key_wr) key_mem[key_addr] <= key_r;
    key_rd_r <= key_mem[key_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cmd.cnt_clr) count_r <= '0;
    else if (cmd.pt_wr) count_r <= count_r + 1'b1;
  end
  assign count = count_r;
  assign sts.full = (32'(count_r) >= MAX_POINTS);

  // compare stage: distance of the point read last cycle
  logic [hlns_pkg::PT_W-1:0] dmask, diff;
  logic [hlns_pkg::DIST_W-1:0] ham;
  always_comb begin
    for (int i = 0; i < hlns_pkg::PT_W; i++)
      dmask[i] = (i < 32'(dims_eff));
    diff = (pt_r ^ pt_rd_r) & dmask;
    ham = '0;
    for (int i = 0; i < hlns_pkg::PT_W; i++)
      ham = ham + hlns_pkg::DIST_W'(diff[i]);
  end

  logic                        found_r;
  logic [hlns_pkg::PT_W-1:0]   nb_r;
  logic [hlns_pkg::DIST_W-1:0] best_r;
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      found_r <= 1'b0;
      nb_r    <= '0;
      best_r  <= dist_limit;
    end else if (cmd.cmp && (key_rd_r == key_r) && (ham < best_r)) begin
      found_r <= 1'b1;
      nb_r    <= pt_rd_r;
      best_r  <= ham;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_kind  <= act_r;
      res_found <= (act_r == hlns_pkg::ACT_QUERY) && found_r;
      res_nb    <= (act_r == hlns_pkg::ACT_QUERY) ? nb_r : '0;
      res_dist  <= (act_r == hlns_pkg::ACT_QUERY) ? best_r : '0;
      res_full  <= (act_r == hlns_pkg::ACT_INSERT) && full_r;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/hlns_ctrl.sv -----
`default_nettype none
module hlns_ctrl #(
  parameter int TABLES     = hlns_pkg::TABLES_DEF,
  parameter int PLANES     = hlns_pkg::PLANES_DEF,
  parameter int DIM        = hlns_pkg::DIM_DEF,
  parameter int MAX_POINTS = hlns_pkg::MAX_POINTS_DEF,
  localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1,
  localparam int DW = (DIM > 1) ? $clog2(DIM) : 1,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire [hlns_pkg::ACT_W-1:0]  in_action,
  output logic                       out_valid,
  input  wire                        out_ready,
  input  wire [hlns_pkg::DIST_W-1:0] dims_eff,
  input  wire [hlns_pkg::DIST_W-1:0] tables_eff,
  input  wire [CW-1:0]               count,
  input  wire hlns_pkg::hlns_sts_t   sts,
  output hlns_pkg::hlns_cmd_t        cmd,
  output logic [TW-1:0]              t_idx,
  output logic [DW-1:0]              d_idx,
  output logic [AW-1:0]              p_idx
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_HCLR  = 4'd2;
  localparam logic [3:0] S_HSUM  = 4'd3;
  localparam logic [3:0] S_HLAST = 4'd4;
  localparam logic [3:0] S_HKEY  = 4'd5;
  localparam logic [3:0] S_IWR   = 4'd6;
  localparam logic [3:0] S_QRD   = 4'd7;
  localparam logic [3:0] S_QCMP  = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_RES   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]             state_r, state_nxt;
  logic [hlns_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [TW:0]            t_r, t_nxt;
  logic [DW:0]            d_r, d_nxt;
  logic [CW-1:0]          p_r, p_nxt;   // points left to walk

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= hlns_pkg::ACT_LOAD;
      t_r <= '0; d_r <= '0; p_r <= '0;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      t_r <= t_nxt; d_r <= d_nxt; p_r <= p_nxt;
    end
  end

  assign t_idx = t_r[TW-1:0];
  assign d_idx = d_r[DW-1:0];
  assign p_idx = AW'(p_r - 1'b1);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  logic t_last;
  assign t_last = (32'(t_r) + 1 >= ((act_r == hlns_pkg::ACT_INSERT) ? TABLES
                                     : 32'(tables_eff)));

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r;
    t_nxt = t_r; d_nxt = d_r; p_nxt = p_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          act_nxt = in_action;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        t_nxt = '0; d_nxt = '0;
        unique case (act_r)
          hlns_pkg::ACT_LOAD: begin
            cmd.load_wr = 1'b1;
            state_nxt = S_RES;
          end
          hlns_pkg::ACT_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt = S_RES;
          end
          hlns_pkg::ACT_INSERT: state_nxt = sts.full ? S_RES : S_HCLR;
          default: state_nxt = (tables_eff == '0) ? S_RES : S_HCLR;
        endcase
      end
      // hash one table: read dims in turn, accumulate one behind
      S_HCLR: begin
        cmd.sum_clr = 1'b1;
        d_nxt = '0;
        state_nxt = (dims_eff == '0) ? S_HKEY : S_HSUM;
        if (dims_eff != '0) d_nxt = (DW+1)'(1);
      end
      S_HSUM: begin
        cmd.sum_acc = 1'b1;
        if (32'(d_r) >= 32'(dims_eff)) state_nxt = S_HLAST;
        else d_nxt = d_r + 1'b1;
      end
      S_HLAST: state_nxt = S_HKEY;
      // insert points p_idx at the new slot, query at the newest point
      S_HKEY: begin
        cmd.key_done = 1'b1;
        p_nxt = (act_r == hlns_pkg::ACT_INSERT) ? count + 1'b1 : count;
        state_nxt = (act_r == hlns_pkg::ACT_INSERT) ? S_IWR
                    : ((count == '0) ? S_NEXT : S_QRD);
      end
      S_IWR: begin
        cmd.key_wr = 1'b1;
        state_nxt = S_NEXT;
      end
      S_QRD: state_nxt = S_QCMP;
      S_QCMP: begin
        cmd.cmp = 1'b1;
        p_nxt = p_r - 1'b1;
        state_nxt = (p_r == CW'(1)) ? S_NEXT : S_QRD;
      end
      // next table starts reading at dim zero
      S_NEXT: begin
        if (t_last) begin
          if (act_r == hlns_pkg::ACT_INSERT) cmd.pt_wr = 1'b1;
          state_nxt = S_RES;
        end else begin
          t_nxt = t_r + 1'b1;
          d_nxt = '0;
          state_nxt = S_HCLR;
        end
      end
      S_RES: begin
        cmd.res_load = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/hyperplane_lsh_neighbor_search_top.sv -----
// sequencing: load, clear and full insert answer directly; insert and query hash each
//   table in turn with the shared hash accumulator, and query also walks the stored
//   points of each table one at a time through the point store
// throughput: one request at a time, next taken after the result is accepted
// reset: synchronous active-low rst_n clears control and point count, sets config registers to defaults
`default_nettype none
module hyperplane_lsh_neighbor_search_top #(
  parameter int TABLES     = hlns_pkg::TABLES_DEF,
  parameter int PLANES     = hlns_pkg::PLANES_DEF,
  parameter int DIM        = hlns_pkg::DIM_DEF,
  parameter int MAX_POINTS = hlns_pkg::MAX_POINTS_DEF
) (
  input  wire clk,
  input  wire rst_n,
  hlns_in_if.sink    in_ch,
  hlns_out_if.source out_ch,
  input  wire                               cfg_we,
  input  wire [hlns_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [hlns_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int PW = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // config registers
  logic [4:0] dims_r, limit_r;
  logic [2:0] planes_r;
  logic [3:0] tables_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 5'd10; planes_r <= 3'd4; tables_r <= 4'd8; limit_r <= 5'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hlns_pkg::REG_DIMS:   dims_r   <= cfg_data;
        hlns_pkg::REG_PLANES: planes_r <= cfg_data[2:0];
        hlns_pkg::REG_TABLES: tables_r <= cfg_data[3:0];
        hlns_pkg::REG_LIMIT:  limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated settings
  logic [hlns_pkg::DIST_W-1:0] dims_eff, tables_eff;
  logic [PW:0] planes_eff;
  assign dims_eff   = (32'(dims_r) > DIM) ? hlns_pkg::DIST_W'(DIM) : dims_r;
  assign tables_eff = (32'(tables_r) > TABLES) ? hlns_pkg::DIST_W'(TABLES)
                                               : hlns_pkg::DIST_W'(tables_r);
  assign planes_eff = (32'(planes_r) > PLANES) ? (PW+1)'(PLANES) : (PW+1)'(planes_r);

  hlns_pkg::hlns_cmd_t cmd;
  hlns_pkg::hlns_sts_t sts;
  logic [TW-1:0] t_idx;
  logic [DW-1:0] d_idx;
  logic [AW-1:0] p_idx;
  logic [CW-1:0] count;

  hlns_ctrl #(.TABLES(TABLES), .PLANES(PLANES), .DIM(DIM), .MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .dims_eff, .tables_eff, .count, .sts, .cmd, .t_idx, .d_idx, .p_idx
  );

  hlns_datapath #(.TABLES(TABLES), .PLANES(PLANES), .DIM(DIM), .MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .t_idx, .d_idx, .p_idx,
    .dims_eff, .planes_eff, .dist_limit(limit_r), .count,
    .in_action(in_ch.action), .in_table_index(in_ch.table_index),
    .in_plane_index(in_ch.plane_index), .in_dim_index(in_ch.dim_index),
    .in_coefficient(in_ch.coefficient), .in_point_bits(in_ch.point_bits),
    .res_kind(out_ch.kind), .res_found(out_ch.found), .res_nb(out_ch.neighbour_bits),
    .res_dist(out_ch.distance), .res_full(out_ch.store_full)
  );
endmodule
`default_nettype wire

// ----- rtl/hlns_checker.sv -----
`default_nettype none
module hlns_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire [1:0] out_kind,
  input wire out_found,
  input wire [15:0] out_nb,
  input wire [4:0] out_dist,
  input wire out_full
);
  // no new request while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while result pending");

  // result neighbour and distance hold while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_nb) && $stable(out_dist))
    else $error("result changed under stall");

  // non-query fields are zero
  a_nonquery: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != hlns_pkg::ACT_QUERY) |->
      !out_found && out_nb == 16'd0 && out_dist == 5'd0)
    else $error("non-query fields set");

  // store_full only on insert
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full |-> out_kind == hlns_pkg::ACT_INSERT)
    else $error("full flag outside insert");
endmodule

bind hyperplane_lsh_neighbor_search_top hlns_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.kind),
  .out_found(out_ch.found), .out_nb(out_ch.neighbour_bits), .out_dist(out_ch.distance),
  .out_full(out_ch.store_full)
);
`default_nettype wire

// ----- dv/tb_hyperplane_lsh_neighbor_search_top.sv -----
`timescale 1ns / 100ps
module tb_hyperplane_lsh_neighbor_search_top;
  import hlns_pkg::*;

  localparam int NTAB = TABLES_DEF;
  localparam int NPLN = PLANES_DEF;
  localparam int NDIM = DIM_DEF;
  localparam int NPTS = MAX_POINTS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 12;

  typedef enum logic [1:0] {ST_REQ, ST_CFG, ST_DRAIN, ST_HOLD} step_kind_e;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [TIDX_W-1:0]        table_index;
    logic [PIDX_W-1:0]        plane_index;
    logic [DIDX_W-1:0]        dim_index;
    logic signed [COEF_W-1:0] coefficient;
    logic [PT_W-1:0]          point_bits;
  } lsh_req_t;

  typedef struct packed {
    logic [ACT_W-1:0]  kind;
    logic              found;
    logic [PT_W-1:0]   neighbour_bits;
    logic [DIST_W-1:0] distance;
    logic              store_full;
  } lsh_rsp_t;

  typedef struct {
    step_kind_e            sk;
    lsh_req_t              req;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hlns_in_if  in_bus ();
  hlns_out_if out_bus ();

  hyperplane_lsh_neighbor_search_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus.sink), .out_ch(out_bus.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the engine state
  logic signed [COEF_W-1:0] coef_mem [NTAB*NPLN*NDIM];
  logic [PT_W-1:0] point_mem [NPTS];
  logic [NPLN-1:0] key_mem [NTAB*NPTS];
  int unsigned point_cnt = 0;
  logic [4:0] r_dims = 5'd10, r_planes = 5'd4, r_tables = 5'd8, r_limit = 5'd10;

  step_t    plan_q[$];
  lsh_rsp_t answer_q[$];
  int mismatches = 0, n_req = 0, n_rsp = 0, n_found = 0, n_full = 0;
  int n_cfg = 0, idle_cycles = 0;
  bit req_taken = 0;
  bit hold_req = 0;
  int gap_left = 0, settle = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [NPLN-1:0] plane_key(int t, logic [PT_W-1:0] p);
    int d, k, s;
    logic [NPLN-1:0] key;
    d = (r_dims > NDIM) ? NDIM : r_dims;
    k = (r_planes > NPLN) ? NPLN : r_planes;
    key = '0;
    for (int j = 0; j < k; j++) begin
      s = 0;
      for (int i = 0; i < d; i++)
        if (p[i]) s += coef_mem[(t*NPLN + j)*NDIM + i];
      if (s > 0) key[j] = 1'b1;
    end
    return key;
  endfunction

  // apply one request to the shadow state and return its answer
  function automatic lsh_rsp_t search_engine_step(lsh_req_t r);
    lsh_rsp_t a;
    int d, nt, best, h;
    logic [PT_W-1:0] m;
    logic [NPLN-1:0] q;
    a = '0;
    a.kind = r.action;
    case (r.action)
      ACT_LOAD: coef_mem[(r.table_index*NPLN + r.plane_index)*NDIM + r.dim_index] =
                  r.coefficient;
      ACT_INSERT: begin
        if (point_cnt >= NPTS) a.store_full = 1'b1;
        else begin
          point_mem[point_cnt] = r.point_bits;
          for (int t = 0; t < NTAB; t++) key_mem[t*NPTS + point_cnt] = plane_key(t, r.point_bits);
          point_cnt++;
        end
      end
      ACT_QUERY: begin
        d = (r_dims > NDIM) ? NDIM : r_dims;
        m = (d >= NDIM) ? '1 : PT_W'((32'd1 << d) - 1);
        nt = (r_tables > NTAB) ? NTAB : r_tables;
        best = r_limit;
        a.distance = r_limit;
        for (int t = 0; t < nt; t++) begin
          q = plane_key(t, r.point_bits);
          for (int i = int'(point_cnt) - 1; i >= 0; i--)
            if (key_mem[t*NPTS + i] == q) begin
              h = $countones((r.point_bits ^ point_mem[i]) & m);
              if (h < best) begin
                best = h;
                a.found = 1'b1;
                a.neighbour_bits = point_mem[i];
                a.distance = DIST_W'(h);
              end
            end
        end
      end
      default: point_cnt = 0;
    endcase
    return a;
  endfunction

  // request driver, changes inputs on the falling edge
  always @(negedge clk) begin
    bit cfg_pulse;
    cfg_pulse = 1'b0;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !req_taken) begin
      // keep offering the same request
    end else if (gap_left > 0) begin
      gap_left--;
      in_bus.valid <= 1'b0;
    end else if (plan_q.size() == 0) begin
      in_bus.valid <= 1'b0;
    end else begin
      case (plan_q[0].sk)
        ST_REQ: begin
          in_bus.valid       <= 1'b1;
          in_bus.action      <= plan_q[0].req.action;
          in_bus.table_index <= plan_q[0].req.table_index;
          in_bus.plane_index <= plan_q[0].req.plane_index;
          in_bus.dim_index   <= plan_q[0].req.dim_index;
          in_bus.coefficient <= plan_q[0].req.coefficient;
          in_bus.point_bits  <= plan_q[0].req.point_bits;
          void'(plan_q.pop_front());
          case ($urandom_range(0, 99)) inside
            [0:59]:  gap_left = 0;
            [60:91]: gap_left = $urandom_range(1, 3);
            default: gap_left = $urandom_range(10, 60);
          endcase
        end
        ST_HOLD: begin
          hold_req = 1;
          in_bus.valid <= 1'b0;
          void'(plan_q.pop_front());
        end
        default: begin
          // idle block needed: everything answered, then a settle pause
          in_bus.valid <= 1'b0;
          if (answer_q.size() != 0) settle = 0;
          else if (settle < SETTLE_CYCLES) settle++;
          else begin
            settle = 0;
            if (plan_q[0].sk == ST_CFG) begin
              cfg_pulse = 1'b1;
              cfg_index <= plan_q[0].reg_idx;
              cfg_data  <= plan_q[0].reg_val;
              case (plan_q[0].reg_idx)
                REG_DIMS:   r_dims   = plan_q[0].reg_val;
                REG_PLANES: r_planes = plan_q[0].reg_val;
                REG_TABLES: r_tables = plan_q[0].reg_val;
                default:    r_limit  = plan_q[0].reg_val;
              endcase
              n_cfg++;
            end
            void'(plan_q.pop_front());
          end
        end
      endcase
    end
    cfg_we <= cfg_pulse;
  end

  // answer receiver, random back-pressure and one long hold-off
  int hold_left = 0, burst_left = 0, rgap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_req && hold_left == 0) begin
      hold_req = 0;
      hold_left = 3000;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_bus.ready <= 1'b1;
    end else if (rgap > 0) begin
      rgap--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:54]:  rgap = 0;
        [55:89]: rgap = $urandom_range(1, 3);
        [90:95]: rgap = $urandom_range(10, 80);
        default: burst_left = $urandom_range(50, 400);
      endcase
    end
  end

  // monitor: predict on request, compare on answer, watchdog
  always @(posedge clk) begin
    lsh_req_t r;
    lsh_rsp_t got, want;
    req_taken = 0;
    if (rst_n) begin
      idle_cycles++;
      if (in_bus.valid && in_bus.ready) begin
        r = '{in_bus.action, in_bus.table_index, in_bus.plane_index, in_bus.dim_index,
              in_bus.coefficient, in_bus.point_bits};
        answer_q.push_back(search_engine_step(r));
        req_taken = 1;
        n_req++;
        idle_cycles = 0;
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.kind, out_bus.found, out_bus.neighbour_bits, out_bus.distance,
                out_bus.store_full};
        idle_cycles = 0;
        n_rsp++;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected answer kind=%0d", got.kind);
        end else begin
          want = answer_q.pop_front();
          if (got.found) n_found++;
          if (got.store_full) n_full++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("answer %0d: exp kind=%0d found=%0d nb=%h dist=%0d full=%0d, got kind=%0d found=%0d nb=%h dist=%0d full=%0d",
                       n_rsp, want.kind, want.found, want.neighbour_bits, want.distance,
                       want.store_full, got.kind, got.found, got.neighbour_bits,
                       got.distance, got.store_full);
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("hyperplane_lsh_neighbor_search_top regression: fail");
        $finish;
      end
    end
  end

  // plan building helpers
  logic [PT_W-1:0] seen_pts[$];

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return -11'sd1000;
      1: return 11'sd1000;
      default: return COEF_W'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic add_req(logic [ACT_W-1:0] act, logic [PT_W-1:0] p,
                         logic signed [COEF_W-1:0] c);
    step_t s;
    s.sk = ST_REQ;
    s.req = '{act, TIDX_W'($urandom), PIDX_W'($urandom), DIDX_W'($urandom), c, p};
    plan_q.push_back(s);
  endtask

  task automatic add_load(int t, int pl, int dm, logic signed [COEF_W-1:0] c);
    step_t s;
    s.sk = ST_REQ;
    s.req = '{ACT_LOAD, TIDX_W'(t), PIDX_W'(pl), DIDX_W'(dm), c, PT_W'($urandom)};
    plan_q.push_back(s);
  endtask

  task automatic add_ctl(step_kind_e k, logic [CFG_IDX_W-1:0] idx, int v);
    step_t s;
    s.sk = k;
    s.reg_idx = idx;
    s.reg_val = CFG_DATA_W'(v);
    plan_q.push_back(s);
  endtask

  task automatic set_regs(int d, int p, int t, int l);
    add_ctl(ST_CFG, REG_DIMS, d);
    add_ctl(ST_CFG, REG_PLANES, p);
    add_ctl(ST_CFG, REG_TABLES, t);
    add_ctl(ST_CFG, REG_LIMIT, l);
  endtask

  // point near an earlier one, or fresh
  function automatic logic [PT_W-1:0] pick_point();
    logic [PT_W-1:0] p;
    if (seen_pts.size() == 0 || $urandom_range(0, 3) == 0) return PT_W'($urandom);
    p = seen_pts[$urandom_range(0, seen_pts.size() - 1)];
    repeat ($urandom_range(0, 3)) p[$urandom_range(0, PT_W - 1)] ^= 1'b1;
    return p;
  endfunction

  initial begin
    int act_roll, clear_pct;
    logic [PT_W-1:0] p;
    in_bus.valid = 1'b0; in_bus.action = '0; in_bus.table_index = '0;
    in_bus.plane_index = '0; in_bus.dim_index = '0; in_bus.coefficient = '0;
    in_bus.point_bits = '0; out_bus.ready = 1'b0;

    // every coefficient written before any hash reads it
    for (int t = 0; t < NTAB; t++)
      for (int pl = 0; pl < NPLN; pl++)
        for (int dm = 0; dm < NDIM; dm++) add_load(t, pl, dm, rand_coef());

    // directed: field extremes, every action, empty store, zero and oversized registers
    add_req(ACT_QUERY, 16'hffff, '0);
    add_load(7, 3, 15, -11'sd1000);
    add_load(0, 0, 0, 11'sd1000);
    add_req(ACT_INSERT, 16'h0000, '0);
    add_req(ACT_INSERT, 16'hffff, '0);
    add_req(ACT_QUERY, 16'hfffe, '0);
    add_req(ACT_QUERY, 16'h0000, '0);
    add_req(ACT_QUERY, 16'h5a5a, '0);
    set_regs(0, 0, 0, 0);
    add_req(ACT_QUERY, 16'hffff, '0);
    add_req(ACT_INSERT, 16'h1234, '0);
    set_regs(16, 4, 8, 16);
    add_req(ACT_QUERY, 16'h1235, '0);
    add_req(ACT_QUERY, 16'hffff, '0);
    set_regs(31, 7, 15, 31);
    add_req(ACT_QUERY, 16'hedcb, '0);
    add_req(ACT_INSERT, 16'hedcb, '0);
    add_req(ACT_QUERY, 16'hedcb, '0);
    set_regs(0, 4, 8, 1);
    add_req(ACT_QUERY, 16'h8000, '0);
    add_req(ACT_CLEAR, 16'h0000, '0);
    add_req(ACT_QUERY, 16'hffff, '0);
    set_regs(16, 4, 8, 16);
    for (int i = 0; i < NPTS + 2; i++) add_req(ACT_INSERT, PT_W'($urandom), '0);
    add_req(ACT_QUERY, 16'h0f0f, '0);
    add_req(ACT_CLEAR, 16'h0000, '0);

    // random phases with mostly clustered points
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0) set_regs(16, 4, 8, 16);
      else set_regs($urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 15),
                    $urandom_range(0, 31));
      clear_pct = (ph % 2) ? 1 : 6;
      for (int i = 0; i < 90; i++) begin
        act_roll = $urandom_range(0, 99);
        if (act_roll < 30)
          add_load($urandom_range(0, NTAB - 1), $urandom_range(0, NPLN - 1),
                   $urandom_range(0, NDIM - 1), rand_coef());
        else if (act_roll < 60) begin
          p = pick_point();
          seen_pts.push_back(p);
          add_req(ACT_INSERT, p, rand_coef());
        end else if (act_roll < 100 - clear_pct)
          add_req(ACT_QUERY, pick_point(), rand_coef());
        else
          add_req(ACT_CLEAR, PT_W'($urandom), rand_coef());
        if (ph == 4 && i == 60) add_ctl(ST_HOLD, REG_DIMS, 0);
        if (ph == 7 && i == 40) add_ctl(ST_DRAIN, REG_DIMS, 0);
      end
      add_ctl(ST_DRAIN, REG_DIMS, 0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (plan_q.size() == 0 && answer_q.size() == 0 && !in_bus.valid);
    repeat (100) @(posedge clk);
    $display("covered %0d requests, %0d answers, %0d register writes", n_req, n_rsp, n_cfg);
    $display("queries with a neighbour: %0d, dropped inserts: %0d, mismatches: %0d",
             n_found, n_full, mismatches);
    if (mismatches == 0 && answer_q.size() == 0)
      $display("hyperplane_lsh_neighbor_search_top regression: pass");
    else
      $display("hyperplane_lsh_neighbor_search_top regression: fail");
    $finish;
  end

endmodule
